@@ hdl/tbb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbb_pkg: shared types and constants of the token bucket limiter
// Holds request codes, register indexes, datapath widths and the control
// and status bundles between the sequencer and the divide unit.
// ----------------------------------------------------------------------------
package tbb_pkg;

  localparam int DataW = 32;
  localparam int SizeW = 16;
  localparam int ModeW = 2;
  localparam int CfgIdxW = 2;

  // Request kinds carried in tuser
  localparam logic [ModeW-1:0] ModeAcquire = 2'd0;
  localparam logic [ModeW-1:0] ModeError   = 2'd1;
  localparam logic [ModeW-1:0] ModeSuccess = 2'd2;

  // Register indexes of the write port
  localparam logic [CfgIdxW-1:0] RegBucketSize  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRefill      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBackoffMin  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBackoffMax  = 2'd3;

  // Register reset values
  localparam logic [SizeW-1:0] BucketSizeRst = 16'd1;
  localparam logic [DataW-1:0] RefillRst     = 32'd65536;
  localparam logic [DataW-1:0] BackoffMinRst = 32'd1000;
  localparam logic [DataW-1:0] BackoffMaxRst = 32'd60000;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/tbb_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbb_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle through one shared
// subtract and compare; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module tbb_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tbb_pkg::div_ctrl_t       ctrl_i,
  input  logic [tbb_pkg::DataW-1:0] dividend_i,
  input  logic [tbb_pkg::DataW-1:0] divisor_i,
  output tbb_pkg::div_stat_t       stat_o,
  output logic [tbb_pkg::DataW-1:0] quotient_o
);
  import tbb_pkg::*;

  localparam int CntW = $clog2(DataW);
  localparam logic [CntW-1:0] CntLast = CntW'(DataW - 1);

  logic [DataW:0]   rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  logic [DataW:0] rem_sh;
  logic [DataW:0] rem_sub;
  logic           fits;

  // One step: shift in the next dividend bit, subtract when it fits
  assign rem_sh  = {rem_q[DataW-1:0], quo_q[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    rem_d = fits ? rem_sub : rem_sh;
    quo_d = {quo_q[DataW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

@@ hdl/token_bucket_with_backoff.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_bucket_with_backoff: token bucket rate limiter with error backoff
// Acquire requests refill a fixed-point token level and take one token or
// report the refill wait; error requests double the backoff up to a cap;
// success requests restore the minimum backoff.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Payload
//  --------  ---  -------------------  ---------------------------------------
//  s_*       in   s_tvalid/s_tready    tuser: mode; tdata: elapsed_ticks
//  m_*       out  m_tvalid/m_tready    tuser: granted;
//                                      tdata: wait_ticks, token_level
//  cfg_*     in   cfg_we (no wait)     cfg_idx selects, cfg_wdata value
//
//  Error, success and unused requests pass from StIdle through StDone to output.
//  An acquire steps through multiply, refill add and token check; then a
//  bit-serial divide of one bit per cycle sets the wait when the bucket is
//  empty and the refill rate is nonzero; a granted acquire skips the divide.
//  s_tready is high only while the sequencer is idle; one finished result
//  may wait in the output register while the next request is accepted.
//  Reset fills the bucket to one token of capacity bucket_size = 1 and sets
//  the backoff to its minimum; writing bucket_size refills the bucket.
// ----------------------------------------------------------------------------
module token_bucket_with_backoff #(
  parameter int FractionBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [tbb_pkg::ModeW-1:0]   s_tuser_i,   // [1:0] mode
  input  logic [tbb_pkg::DataW-1:0]   s_tdata_i,   // [31:0] elapsed_ticks
  // result channel
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic                        m_tuser_o,   // [0] granted
  output logic [2*tbb_pkg::DataW-1:0] m_tdata_o,   // [31:0] wait_ticks,
                                                   // [63:32] token_level
  // register write port
  input  logic                        cfg_we_i,
  input  logic [tbb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tbb_pkg::DataW-1:0]   cfg_wdata_i
);
  import tbb_pkg::*;

  localparam int CapW = SizeW + FractionBits + 1;
  localparam logic [DataW-1:0] One = DataW'(1) << FractionBits;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StAdd  = 3'd2;
  localparam logic [2:0] StChk  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  // Configuration registers
  logic [SizeW-1:0] bucket_q;
  logic [DataW-1:0] refill_q, bmin_q, bmax_q;

  // Limiter state
  logic [DataW-1:0] tokens_q, backoff_q;

  // Sequencer and datapath registers
  logic [2:0]         state_q;
  logic [DataW-1:0]   elapsed_q;
  logic [2*DataW-1:0] prod_q;
  logic [DataW-1:0]   head_q, cap_q, level_q;
  logic               full_q;
  logic               res_grant_q;
  logic [DataW-1:0]   res_wait_q;

  // Output register
  logic               m_valid_q;
  logic               m_grant_q;
  logic [2*DataW-1:0] m_data_q;

  // Capacity of a bucket size, saturated to the level width
  function automatic logic [DataW-1:0] cap_of(input logic [SizeW-1:0] size);
    logic [CapW-1:0] wide;
    wide = CapW'(size) << FractionBits;
    if (wide > CapW'({DataW{1'b1}})) begin
      return {DataW{1'b1}};
    end
    return wide[DataW-1:0];
  endfunction

  logic [DataW-1:0]   cap_now;
  logic [2*DataW-1:0] prod_w;
  logic [DataW:0]     dbl_w;
  logic               in_acc, out_free;

  assign cap_now  = cap_of(bucket_q);
  assign prod_w   = 64'(elapsed_q) * 64'(refill_q);
  assign dbl_w    = {backoff_q, 1'b0};
  assign in_acc   = s_tvalid_i && s_tready_o;
  assign out_free = !m_valid_q || m_tready_i;

  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [DataW-1:0] div_quo;

  assign div_ctrl.start = (state_q == StChk) && (level_q < One) && (refill_q != '0);

  tbb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (One - level_q),
    .divisor_i  (refill_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bucket_q  <= BucketSizeRst;
      refill_q  <= RefillRst;
      bmin_q    <= BackoffMinRst;
      bmax_q    <= BackoffMaxRst;
      tokens_q  <= cap_of(BucketSizeRst);
      backoff_q <= BackoffMinRst;
      m_valid_q <= 1'b0;
    end else begin
      // register writes must arrive only while idle; the block does not enforce it
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegBucketSize: begin
            bucket_q <= cfg_wdata_i[SizeW-1:0];
            tokens_q <= cap_of(cfg_wdata_i[SizeW-1:0]);
          end
          RegRefill:     refill_q <= cfg_wdata_i;
          RegBackoffMin: bmin_q   <= cfg_wdata_i;
          RegBackoffMax: bmax_q   <= cfg_wdata_i;
          default: ;
        endcase
      end

      // drop the held result once taken; a result leaving StDone replaces it
      if (m_valid_q && m_tready_i && (state_q != StDone)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_acc) begin
            case (s_tuser_i)
              ModeAcquire: state_q <= StMul;
              ModeError: begin
                // double without wrap, then cap
                if (dbl_w > {1'b0, bmax_q}) begin
                  backoff_q <= bmax_q;
                end else begin
                  backoff_q <= dbl_w[DataW-1:0];
                end
                state_q <= StDone;
              end
              ModeSuccess: begin
                backoff_q <= bmin_q;
                state_q   <= StDone;
              end
              default: state_q <= StDone;
            endcase
          end
        end
        StMul: state_q <= StAdd;
        StAdd: state_q <= StChk;
        StChk: begin
          if (level_q >= One) begin
            tokens_q <= level_q - One;
            state_q  <= StDone;
          end else begin
            tokens_q <= '0;
            state_q  <= (refill_q == '0) ? StDone : StDiv;
          end
        end
        StDiv: begin
          if (div_stat.done) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          elapsed_q   <= s_tdata_i;
          res_grant_q <= 1'b0;
          if (s_tuser_i == ModeError) begin
            res_wait_q <= (dbl_w > {1'b0, bmax_q}) ? bmax_q : dbl_w[DataW-1:0];
          end else begin
            res_wait_q <= '0;
          end
        end
      end
      StMul: begin
        prod_q <= prod_w;
        cap_q  <= cap_now;
        full_q <= tokens_q >= cap_now;
        head_q <= cap_now - tokens_q;
      end
      StAdd: begin
        // saturate at capacity with no wrap at any width
        if (full_q || prod_q >= {{DataW{1'b0}}, head_q}) begin
          level_q <= cap_q;
        end else begin
          level_q <= tokens_q + prod_q[DataW-1:0];
        end
      end
      StChk: begin
        if (level_q >= One) begin
          res_grant_q <= 1'b1;
          res_wait_q  <= '0;
        end else begin
          res_wait_q <= {DataW{1'b1}};
        end
      end
      StDiv: begin
        if (div_stat.done) begin
          res_wait_q <= div_quo;
        end
      end
      StDone: begin
        if (out_free) begin
          m_grant_q <= res_grant_q;
          m_data_q  <= {tokens_q, res_wait_q};
        end
      end
      default: ;
    endcase
  end

  assign s_tready_o = (state_q == StIdle);
  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = m_grant_q;
  assign m_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  // the divider starts only from the token check
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |-> state_q == StChk)
    else $error("divider started outside the token check");

  // a divide result arrives only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == StDiv)
    else $error("divide finished while not waited for");

  // while waiting on the divider it is busy or just finished
  a_div_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> div_stat.busy || div_stat.done)
    else $error("sequencer waits on an idle divider");

  // a granted result carries no wait
  a_grant_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_grant_q |-> m_data_q[DataW-1:0] == '0)
    else $error("granted result with a nonzero wait");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the token bucket limiter with backoff
// Drives acquire, error, success and unused requests through the stream
// ports under random sender gaps and receiver stalls. A scoreboard predicts
// the grant, wait and token level of every request and compares each result.
// ----------------------------------------------------------------------------
module tb_top;
  import tbb_pkg::*;

  localparam int ClkPeriod     = 20;
  localparam int FracBits      = 16;
  localparam int DrainCycles   = 48;    // longer than a full acquire with a divide
  localparam int QuietLimit    = 4000;  // cycles without any handshake
  localparam int RandomPhases  = 8;
  localparam int PhaseRequests = 160;
  localparam int MaxPrinted    = 40;

  // Mode value the block must ignore apart from echoing the level
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic             granted;
    logic [DataW-1:0] wait_ticks;
    logic [DataW-1:0] level;
  } outcome_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the limiter state and queues the outcome of every
  // accepted request until the matching result arrives.
  // --------------------------------------------------------------------------
  class bucket_scoreboard;
    logic [SizeW-1:0] bucket_size;
    logic [DataW-1:0] refill;
    logic [DataW-1:0] backoff_min;
    logic [DataW-1:0] backoff_max;
    logic [DataW-1:0] tokens;
    logic [DataW-1:0] backoff;
    outcome_t         due_outcomes[$];
    int unsigned      mismatches;

    function new();
      bucket_size = BucketSizeRst;
      refill      = RefillRst;
      backoff_min = BackoffMinRst;
      backoff_max = BackoffMaxRst;
      tokens      = capacity();
      backoff     = backoff_min;
      mismatches  = 0;
    endfunction

    // Whole tokens scaled to fixed point, saturated to the level width
    function logic [DataW-1:0] capacity();
      logic [63:0] full;
      full = {48'd0, bucket_size} << FracBits;
      return (full > 64'hFFFF_FFFF) ? '1 : full[DataW-1:0];
    endfunction

    function void apply_write(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] value);
      case (idx)
        RegBucketSize: begin
          bucket_size = value[SizeW-1:0];
          tokens      = capacity();  // a size write refills the bucket
        end
        RegRefill:     refill      = value;
        RegBackoffMin: backoff_min = value;
        RegBackoffMax: backoff_max = value;
        default: ;
      endcase
    endfunction

    function void note_request(logic [ModeW-1:0] mode, logic [DataW-1:0] elapsed);
      outcome_t         o;
      logic [63:0]      gain;
      logic [63:0]      doubled;
      logic [DataW-1:0] cap;
      logic [DataW-1:0] one;
      logic [DataW-1:0] lvl;
      o = '0;
      case (mode)
        ModeAcquire: begin
          cap  = capacity();
          one  = 32'd1 << FracBits;
          gain = {32'd0, elapsed} * {32'd0, refill};
          lvl  = tokens;
          // saturate at capacity without wrapping; also clamps a high level
          if (lvl >= cap || gain >= {32'd0, cap - lvl}) lvl = cap;
          else lvl = lvl + gain[DataW-1:0];
          if (lvl >= one) begin
            lvl       = lvl - one;
            o.granted = 1'b1;
          end else begin
            o.wait_ticks = (refill == '0) ? '1 : (one - lvl) / refill;
            lvl          = '0;
          end
          tokens = lvl;
        end
        ModeError: begin
          doubled = {31'd0, backoff, 1'b0};
          if (doubled > {32'd0, backoff_max}) doubled = {32'd0, backoff_max};
          backoff      = doubled[DataW-1:0];
          o.wait_ticks = backoff;
        end
        ModeSuccess: backoff = backoff_min;
        default: ;
      endcase
      o.level = tokens;
      due_outcomes.push_back(o);
    endfunction

    task report(string what);
      mismatches++;
      // keep the log short when the block is badly broken
      if (mismatches <= MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic granted, logic [DataW-1:0] wait_ticks, logic [DataW-1:0] level);
      outcome_t want;
      if (due_outcomes.size() == 0) begin
        report($sformatf("result without a pending request: granted %0b wait %0d level %08h",
                         granted, wait_ticks, level));
        return;
      end
      want = due_outcomes.pop_front();
      if (granted !== want.granted)
        report($sformatf("granted %0b, expected %0b", granted, want.granted));
      if (wait_ticks !== want.wait_ticks)
        report($sformatf("wait_ticks %0d, expected %0d", wait_ticks, want.wait_ticks));
      if (level !== want.level)
        report($sformatf("token_level %08h, expected %08h", level, want.level));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               s_tvalid  = 1'b0;
  logic [ModeW-1:0]   s_tuser   = ModeAcquire;
  logic [DataW-1:0]   s_tdata   = '0;
  logic               m_tready  = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = RegBucketSize;
  logic [DataW-1:0]   cfg_wdata = '0;

  logic               s_tready_o;
  logic               m_tvalid_o;
  logic               m_tuser_o;
  logic [2*DataW-1:0] m_tdata_o;

  bucket_scoreboard bucket_sb = new();

  always #(ClkPeriod / 2) clk = ~clk;

  token_bucket_with_backoff #(
    .FractionBits(FracBits)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tuser_i  (s_tuser),
    .s_tdata_i  (s_tdata),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tuser_o  (m_tuser_o),
    .m_tdata_o  (m_tdata_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Monitors: sample at the clock edge, so every value read is the one the
  // block saw at that edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && cfg_we) bucket_sb.apply_write(cfg_idx, cfg_wdata);
  end

  always @(posedge clk) begin
    if (rst_n && s_tvalid && s_tready_o) bucket_sb.note_request(s_tuser, s_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid_o && m_tready)
      bucket_sb.check_result(m_tuser_o, m_tdata_o[DataW-1:0], m_tdata_o[2*DataW-1:DataW]);
  end

  // Watchdog: end the run when nothing moves for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (s_tvalid && s_tready_o) || (m_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: switch between always ready, random ready and long
  // alternating stalls each time the 8-bit style timer wraps.
  // --------------------------------------------------------------------------
  logic [7:0]  style_timer = '0;
  int unsigned ready_style = 0;
  int unsigned hold_cnt    = 0;

  always @(posedge clk) begin
    style_timer <= style_timer + 8'd1;
    if (style_timer == '0) ready_style <= $urandom_range(0, 2);
    case (ready_style)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (hold_cnt != 0) begin
          hold_cnt <= hold_cnt - 1;
        end else begin
          m_tready <= ~m_tready;
          hold_cnt <= $urandom_range(0, 50);
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;

  // Hold the request until accepted; keep tvalid high inside a burst and
  // drop it for a random gap, sometimes none, between bursts.
  task send_request(input logic [ModeW-1:0] mode, input logic [DataW-1:0] elapsed);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= elapsed;
    do @(posedge clk); while (!s_tready_o);
  endtask

  // Stop sending, wait for every pending result, then let the block settle.
  // Step one edge first so the last accepted request is already queued.
  task drain_results();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (bucket_sb.due_outcomes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Leave the write enable high; the caller drops it after the last write
  task write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task configure(input logic [SizeW-1:0] size, input logic [DataW-1:0] rate,
                 input logic [DataW-1:0] bmin, input logic [DataW-1:0] bmax);
    drain_results();
    write_reg(RegBucketSize, {16'd0, size});
    write_reg(RegRefill, rate);
    write_reg(RegBackoffMin, bmin);
    write_reg(RegBackoffMax, bmax);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [SizeW-1:0] size;
    logic [DataW-1:0] rate;
    logic [DataW-1:0] bmin;
    logic [DataW-1:0] bmax;
    logic [ModeW-1:0] mode;
    logic [DataW-1:0] elapsed;
    int unsigned      pick;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one token, one token per tick, backoff 1000 up to 60000
    send_request(ModeAcquire, 32'd0);           // take the only token
    send_request(ModeAcquire, 32'd0);           // empty: wait one tick
    send_request(ModeAcquire, 32'hFFFF_FFFF);   // huge refill saturates
    send_request(ModeUnused, 32'hFFFF_FFFF);    // ignored mode
    repeat (6) send_request(ModeError, 32'd0);  // double up to the cap
    send_request(ModeSuccess, 32'd0);
    send_request(ModeAcquire, 32'd1);

    // Zero capacity: never granted
    drain_results();
    write_reg(RegBucketSize, 32'd0);
    cfg_we <= 1'b0;
    send_request(ModeAcquire, 32'hFFFF_FFFF);

    // Zero refill rate: the wait reads all ones; zero backoff stays zero
    configure(16'd0, 32'd0, 32'd0, 32'd0);
    send_request(ModeAcquire, 32'd5);
    send_request(ModeError, 32'd0);

    // Largest bucket and rate; backoff doubling must not wrap
    configure(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ModeAcquire, 32'hFFFF_FFFF);
    send_request(ModeSuccess, 32'd0);
    send_request(ModeError, 32'd0);

    // Cap below the current backoff, then a minimum write that only a
    // later success picks up
    drain_results();
    write_reg(RegBackoffMax, 32'd5);
    cfg_we <= 1'b0;
    send_request(ModeError, 32'd0);
    drain_results();
    write_reg(RegBackoffMin, 32'd77);
    cfg_we <= 1'b0;
    send_request(ModeError, 32'd0);
    send_request(ModeSuccess, 32'd0);
    send_request(ModeError, 32'd0);

    // Smallest fractional rate: long waits through the divider
    configure(16'd1, 32'd1, 32'd3, 32'd1000);
    send_request(ModeAcquire, 32'd0);
    send_request(ModeAcquire, 32'd0);
    send_request(ModeAcquire, 32'd3);

    // Random phases, each with its own settings
    for (int p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 5))
        0:       size = 16'd1;
        1:       size = 16'hFFFF;
        2:       size = 16'd0;
        3:       size = SizeW'($urandom_range(0, 16'hFFFF));
        default: size = SizeW'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 6))
        0:       rate = 32'd1;
        1:       rate = 32'hFFFF_FFFF;
        2:       rate = $urandom;
        3:       rate = 32'd65536;
        4:       rate = $urandom_range(1, 4096);
        default: rate = $urandom_range(1, 131072);
      endcase
      case ($urandom_range(0, 3))
        0:       bmin = 32'd0;
        1:       bmin = $urandom;
        default: bmin = $urandom_range(0, 2000);
      endcase
      case ($urandom_range(0, 3))
        0:       bmax = 32'hFFFF_FFFF;
        1:       bmax = $urandom;
        default: bmax = $urandom_range(0, 100000);
      endcase
      configure(size, rate, bmin, bmax);

      for (int n = 0; n < PhaseRequests; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      mode = ModeAcquire;
        else if (pick < 80) mode = ModeError;
        else if (pick < 95) mode = ModeSuccess;
        else                mode = ModeUnused;
        // mostly short intervals so the bucket drains and refills in turn
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: elapsed = 32'd0;
          8, 9, 10, 11, 12, 13:   elapsed = $urandom_range(0, 3);
          14, 15, 16:             elapsed = $urandom_range(0, 70000);
          17, 18:                 elapsed = $urandom;
          default:                elapsed = 32'hFFFF_FFFF;
        endcase
        send_request(mode, elapsed);
      end
    end

    drain_results();
    if (bucket_sb.mismatches == 0 && bucket_sb.due_outcomes.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tbb_pkg.sv
hdl/tbb_div.sv
hdl/token_bucket_with_backoff.sv
sim/tb_top.sv
